@@ rtl/lbmp_pkg.sv @@
// Shared types, constants and CORDIC arctangent table for the lidar beam to map point block.
`default_nettype none

package lbmp_pkg;

  // Port widths
  localparam int IN_W    = 16;
  localparam int OUT_W   = 80;
  localparam int CFG_W   = 24;
  localparam int CIDX_W  = 3;
  localparam int ITER_W  = 5;
  localparam int MAX_ITERS = 24;

  // Configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    CFG_SKIP_COUNT     = 3'd0,
    CFG_BEAMS_PER_SCAN = 3'd1,
    CFG_ANGLE_START    = 3'd2,
    CFG_ANGLE_STEP     = 3'd3,
    CFG_RANGE_MIN      = 3'd4,
    CFG_RANGE_MAX      = 3'd5,
    CFG_CELLS_PER_MM   = 3'd6
  } cfg_idx_t;

  // Configuration reset values
  localparam logic [9:0]  RST_SKIP_COUNT  = 10'd0;
  localparam logic [12:0] RST_BEAMS       = 13'd1081;
  localparam logic [15:0] RST_ANGLE_START = 16'hA000;
  localparam logic [15:0] RST_ANGLE_STEP  = 16'd182;
  localparam logic [15:0] RST_RANGE_MIN   = 16'd20;
  localparam logic [15:0] RST_RANGE_MAX   = 16'd29900;
  localparam logic [23:0] RST_CELLS       = 24'd2621;

  // CORDIC gain correction, 0.6072529350 in Q30
  localparam logic [29:0] GAIN_Q30 = 30'd652032874;

  // Controller to datapath commands
  typedef struct packed {
    logic              accept;
    logic              mul0;
    logic              mul1;
    logic              mul2;
    logic              prep;
    logic              iter;
    logic              load;
    logic [ITER_W-1:0] iter_idx;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic item_valid;
    logic out_free;
  } stat_t;

  // atan(2^-i) in units of 2*pi/2^32
  function automatic logic [29:0] atan_lut(input logic [ITER_W-1:0] i);
    logic [29:0] v;
    case (i)
      5'd0:    v = 30'd536870912;
      5'd1:    v = 30'd316933406;
      5'd2:    v = 30'd167458907;
      5'd3:    v = 30'd85004756;
      5'd4:    v = 30'd42667331;
      5'd5:    v = 30'd21354465;
      5'd6:    v = 30'd10679838;
      5'd7:    v = 30'd5340245;
      5'd8:    v = 30'd2670163;
      5'd9:    v = 30'd1335087;
      5'd10:   v = 30'd667544;
      5'd11:   v = 30'd333772;
      5'd12:   v = 30'd166886;
      5'd13:   v = 30'd83443;
      5'd14:   v = 30'd41722;
      5'd15:   v = 30'd20861;
      5'd16:   v = 30'd10430;
      5'd17:   v = 30'd5215;
      5'd18:   v = 30'd2608;
      5'd19:   v = 30'd1304;
      5'd20:   v = 30'd652;
      5'd21:   v = 30'd326;
      5'd22:   v = 30'd163;
      5'd23:   v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/lbmp_ctrl.sv @@
// Sequencing state machine: accept, scale multiply, CORDIC iterations, output load.
`default_nettype none

module lbmp_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  output lbmp_pkg::cmd_t     cmd,
  input  wire lbmp_pkg::stat_t stat
);

  localparam int STEPS = (CORDIC_STEPS > lbmp_pkg::MAX_ITERS) ? lbmp_pkg::MAX_ITERS
                                                              : CORDIC_STEPS;
  localparam logic [lbmp_pkg::ITER_W-1:0] LAST = lbmp_pkg::ITER_W'(STEPS - 1);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL0 = 7'b0000010,
    ST_MUL1 = 7'b0000100,
    ST_MUL2 = 7'b0001000,
    ST_PREP = 7'b0010000,
    ST_ITER = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

  state_t                       state, state_next;
  logic [lbmp_pkg::ITER_W-1:0]  iter_cnt, iter_cnt_next;
  logic                         accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Next state and iteration count
  always_comb begin
    state_next    = state;
    iter_cnt_next = iter_cnt;
    case (state)
      ST_IDLE: begin
        if (accept && stat.item_valid) state_next = ST_MUL0;
      end
      ST_MUL0: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_PREP;
      ST_PREP: begin
        state_next    = ST_ITER;
        iter_cnt_next = '0;
      end
      ST_ITER: begin
        if (iter_cnt == LAST) begin
          state_next = ST_FIN;
        end else begin
          iter_cnt_next = iter_cnt + 1'b1;
        end
      end
      ST_FIN: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Drive datapath commands
  always_comb begin
    cmd.accept   = accept;
    cmd.mul0     = (state == ST_MUL0);
    cmd.mul1     = (state == ST_MUL1);
    cmd.mul2     = (state == ST_MUL2);
    cmd.prep     = (state == ST_PREP);
    cmd.iter     = (state == ST_ITER);
    cmd.load     = (state == ST_FIN) && stat.out_free;
    cmd.iter_idx = iter_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      iter_cnt <= '0;
    end else begin
      state    <= state_next;
      iter_cnt <= iter_cnt_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/lbmp_datapath.sv @@
// Datapath: config registers, beam tracking, scale multiply, CORDIC rotator, output register.
`default_nettype none

module lbmp_datapath #(
  parameter int MAX_BEAMS = 4096
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [lbmp_pkg::IN_W-1:0]   s_tdata,
  input  wire logic [0:0]                  s_tuser,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [lbmp_pkg::OUT_W-1:0]       m_tdata,
  input  wire logic                        cfg_we,
  input  wire logic [lbmp_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [lbmp_pkg::CFG_W-1:0]  cfg_data,
  input  wire lbmp_pkg::cmd_t              cmd,
  output lbmp_pkg::stat_t                  stat
);

  localparam logic [13:0] MAXB = 14'(MAX_BEAMS);

  // Configuration registers
  logic [9:0]  skip_count;
  logic [12:0] beams_per_scan;
  logic [15:0] angle_start;
  logic [15:0] ang_incr;
  logic [15:0] range_min_mm;
  logic [15:0] range_max_mm;
  logic [23:0] cells_per_mm_q16;

  // Beam tracking state
  logic [12:0] beam_count, beam_count_next;
  logic [15:0] beam_angle, beam_angle_next;
  logic [12:0] cnt_eff;
  logic [15:0] ang_eff;
  logic [13:0] nb;
  logic        kept;
  logic        item_valid;

  // Latched item
  logic [15:0] rng;
  logic [15:0] ang;
  logic [11:0] idx;

  // Shared multiplier
  logic [23:0] op_a;
  logic [29:0] op_b;
  logic [53:0] mul_res;
  logic [39:0] prod;
  logic [49:0] plo;
  logic [49:0] phi;

  // Pre-rotation
  logic [69:0]        gsum;
  logic [39:0]        x0;
  logic signed [42:0] x0s;
  logic signed [15:0] a_in;
  logic signed [15:0] a_adj;
  logic [40:0]        dsum;

  // CORDIC registers
  logic signed [42:0] x, y;
  logic signed [33:0] z;
  logic signed [42:0] dx, dy;
  logic signed [33:0] zt;
  logic [19:0]        range_cells;

  // Output rounding
  logic signed [42:0] rx, ry;
  logic [20:0]        x_out, y_out;

  // Output register
  logic [20:0] x_q, y_q;
  logic [19:0] dist_q;
  logic [11:0] beam_q;

  // Clamp a Q8 value (rounded from Q16 by the caller) to 21 signed bits
  function automatic logic [20:0] sat21(input logic signed [42:0] v);
    logic [20:0] r;
    if (v > 43'sd1048575) begin
      r = 21'h0FFFFF;
    end else if (v < -43'sd1048576) begin
      r = 21'h100000;
    end else begin
      r = v[20:0];
    end
    return r;
  endfunction

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_count       <= lbmp_pkg::RST_SKIP_COUNT;
      beams_per_scan   <= lbmp_pkg::RST_BEAMS;
      angle_start      <= lbmp_pkg::RST_ANGLE_START;
      ang_incr         <= lbmp_pkg::RST_ANGLE_STEP;
      range_min_mm     <= lbmp_pkg::RST_RANGE_MIN;
      range_max_mm     <= lbmp_pkg::RST_RANGE_MAX;
      cells_per_mm_q16 <= lbmp_pkg::RST_CELLS;
    end else if (cfg_we) begin
      case (cfg_index)
        lbmp_pkg::CFG_SKIP_COUNT:     skip_count       <= cfg_data[9:0];
        lbmp_pkg::CFG_BEAMS_PER_SCAN: beams_per_scan   <= cfg_data[12:0];
        lbmp_pkg::CFG_ANGLE_START:    angle_start      <= cfg_data[15:0];
        lbmp_pkg::CFG_ANGLE_STEP:     ang_incr         <= cfg_data[15:0];
        lbmp_pkg::CFG_RANGE_MIN:      range_min_mm     <= cfg_data[15:0];
        lbmp_pkg::CFG_RANGE_MAX:      range_max_mm     <= cfg_data[15:0];
        lbmp_pkg::CFG_CELLS_PER_MM:   cells_per_mm_q16 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Classify the incoming beam against the kept window and range gate
  always_comb begin
    cnt_eff = s_tuser[0] ? 13'd0 : beam_count;
    ang_eff = s_tuser[0] ? angle_start : beam_angle;
    nb      = ({1'b0, beams_per_scan} < MAXB) ? {1'b0, beams_per_scan} : MAXB;
    kept    = (cnt_eff >= {3'b000, skip_count}) &&
              (({1'b0, cnt_eff} + {4'b0000, skip_count}) < nb);
    item_valid = kept && (s_tdata > range_min_mm) && (s_tdata < range_max_mm);
    beam_angle_next = kept ? (ang_eff + ang_incr) : ang_eff;
    beam_count_next = (cnt_eff != 13'h1FFF) ? (cnt_eff + 13'd1) : cnt_eff;
  end

  // Advance beam state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      beam_count <= '0;
      beam_angle <= '0;
    end else if (cmd.accept) begin
      beam_count <= beam_count_next;
      beam_angle <= beam_angle_next;
    end
  end

  // Hold the item's fields for the conversion
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rng <= s_tdata;
      ang <= ang_eff;
      idx <= cnt_eff[11:0];
    end
  end

  // Multiplier operand select: range scale, then gain on low and high halves
  always_comb begin
    if (cmd.mul0) begin
      op_a = cells_per_mm_q16;
      op_b = {14'd0, rng};
    end else if (cmd.mul1) begin
      op_a = {4'd0, prod[19:0]};
      op_b = lbmp_pkg::GAIN_Q30;
    end else begin
      op_a = {4'd0, prod[39:20]};
      op_b = lbmp_pkg::GAIN_Q30;
    end
    mul_res = {30'd0, op_a} * {24'd0, op_b};
  end

  always_ff @(posedge clk) begin
    if (cmd.mul0) prod <= mul_res[39:0];
    if (cmd.mul1) plo  <= mul_res[49:0];
    if (cmd.mul2) phi  <= mul_res[49:0];
  end

  // Combine gain products, pre-rotate by a quarter turn, round the distance
  always_comb begin
    gsum  = {phi, 20'd0} + {20'd0, plo};
    // The gain product wraps at 64 bits before the Q30 shift
    x0    = {6'd0, gsum[63:30]};
    x0s   = $signed({3'b000, x0});
    a_in  = $signed(ang);
    dsum  = {1'b0, prod} + 41'd128;
    if (a_in > 16'sd16384) begin
      a_adj = a_in - 16'sd16384;
    end else if (a_in < -16'sd16384) begin
      a_adj = a_in + 16'sd16384;
    end else begin
      a_adj = a_in;
    end
  end

  // One CORDIC micro-rotation
  always_comb begin
    dx = y >>> cmd.iter_idx;
    dy = x >>> cmd.iter_idx;
    zt = $signed({4'b0000, lbmp_pkg::atan_lut(cmd.iter_idx)});
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      if (a_in > 16'sd16384) begin
        x <= '0;
        y <= x0s;
      end else if (a_in < -16'sd16384) begin
        x <= '0;
        y <= -x0s;
      end else begin
        x <= x0s;
        y <= '0;
      end
      z           <= {{2{a_adj[15]}}, a_adj, 16'd0};
      range_cells <= (|dsum[40:28]) ? 20'hFFFFF : dsum[27:8];
    end else if (cmd.iter) begin
      if (!z[33]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - zt;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + zt;
      end
    end
  end

  // Round projections to Q8 and saturate
  always_comb begin
    rx    = (x + 43'sd128) >>> 8;
    ry    = (y + 43'sd128) >>> 8;
    x_out = sat21(rx);
    y_out = sat21(ry);
  end

  // Output register: load a finished point, drop it once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_q    <= x_out;
      y_q    <= y_out;
      dist_q <= range_cells;
      beam_q <= idx;
    end
  end

  assign m_tdata = {6'd0, beam_q, dist_q, y_q, x_q};

  assign stat.item_valid = item_valid;
  assign stat.out_free   = !m_tvalid || m_tready;

endmodule

`default_nettype wire

@@ rtl/lidar_beam_to_map_point_core.sv @@
// A point-giving beam passes MUL0, MUL1, MUL2, PREP, the CORDIC iterations and FIN, which
//   waits for a free output register, then shows on m_tvalid. The single iterative CORDIC
//   rotator and the shared multiplier (three passes per beam) hold s_tready low until the load.
// Beams dropped by the window or range gate take one cycle each while the core is idle.
// Reset (rst, synchronous): clears the controller, beam counter and angle, output valid,
//   and loads the configuration registers with their default values.
// Top level: lidar range samples in, map points out.
`default_nettype none

module lidar_beam_to_map_point_core #(
  parameter int CORDIC_STEPS = 16,
  parameter int MAX_BEAMS    = 4096
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [lbmp_pkg::IN_W-1:0]   s_tdata,   // [15:0] range_mm
  input  wire logic [0:0]                  s_tuser,   // [0] scan_start
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // [20:0] x_cells_q8, [41:21] y_cells_q8, [61:42] dist_cells_q8, [73:62] beam_number,
  // [79:74] zero
  output logic [lbmp_pkg::OUT_W-1:0]       m_tdata,
  input  wire logic                        cfg_we,
  input  wire logic [lbmp_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [lbmp_pkg::CFG_W-1:0]  cfg_data
);

  lbmp_pkg::cmd_t  cmd;
  lbmp_pkg::stat_t stat;

  lbmp_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  lbmp_datapath #(
    .MAX_BEAMS(MAX_BEAMS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire

@@ rtl/lbmp_checker.sv @@
// Port-level checks for the lidar beam to map point core, bound to the top level.
`default_nettype none

module lbmp_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        s_tready,
  input wire logic                        m_tvalid,
  input wire logic                        m_tready,
  input wire logic [lbmp_pkg::OUT_W-1:0]  m_tdata
);

  // No result is pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid high after reset");

  // A stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // A new result is only loaded while the input side is busy converting
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared without a conversion in progress");

  // A busy converter cannot finish while its result slot is blocked
  a_busy_blocked: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready && !s_tready |=> !s_tready)
    else $error("converter went idle with a blocked result");

  // Padding bits of the result stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[79:74] == 6'd0))
    else $error("result padding not zero");

endmodule

bind lidar_beam_to_map_point_core lbmp_checker u_lbmp_checker (.*);

`default_nettype wire
